// ----- rtl/csim_pkg.sv -----
package csim_pkg;

  // Element width is fixed by the item format.
  localparam int ELEM_WIDTH  = 16;
  localparam int MAX_LEN_DEF = 1024;

  localparam int ACC_W   = 48;            // accumulator width, Q24.24
  localparam int PROD_W  = 2 * ELEM_WIDTH; // one element product
  localparam int ROOT_W  = ACC_W - 1;     // square sums are below 2^47
  localparam int PP_W    = 2 * ROOT_W;    // product of the two square sums
  localparam int REM_W   = ROOT_W + 3;    // square root partial remainder
  localparam int FRAC_W  = 14;            // similarity fraction bits
  localparam int NUM_W   = ACC_W + FRAC_W; // divide numerator
  localparam int SIM_W   = 16;
  localparam int ONE_Q14 = 16384;

  localparam int MUL_STEPS  = ROOT_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic signed [ACC_W-1:0] dot_product;
    logic                    zero_norm;
    logic                    too_long;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // register the element products of an accepted item
    logic acc_add;    // add the registered products into the accumulators
    logic fin_init;   // snapshot the sums and clear the accumulators
    logic mul_step;   // one bit of the square sum product
    logic sqrt_step;  // one bit of the square root
    logic div_init;   // form the divide numerator
    logic div_step;   // one quotient bit
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic zero_norm;
  } stat_t;

endpackage

// ----- rtl/csim_ctrl.sv -----
module csim_ctrl
  import csim_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_ACC,
    S_DRAIN,
    S_INIT,
    S_MUL,
    S_SQRT,
    S_DIVI,
    S_DIV,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  logic               take;

  assign in_ready_o  = (state_q == S_ACC);
  assign take        = in_ready_o && in_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = take;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.take    = take;
    cmd_o.acc_add = pend_q;
    case (state_q)
      S_ACC: begin
        if (take && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.fin_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        if (stat_i.zero_norm) begin
          state_d = S_OUT;
        end else begin
          cmd_o.mul_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
            cnt_d   = '0;
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/csim_dp.sv -----
module csim_dp
  import csim_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t out_item_o
);

  localparam int CNT_W = $clog2(MAX_LEN + 2);

  // Saturating add of one product into a 48-bit accumulator.
  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
                                                      logic signed [PROD_W-1:0] x);
    logic signed [ACC_W:0] s;
    s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(x);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  logic signed [PROD_W-1:0] p_ab_q, p_aa_q, p_bb_q;
  logic signed [ACC_W-1:0]  dot_q, sq_a_q, sq_b_q;
  logic [CNT_W-1:0]         cnt_q;

  logic signed [ACC_W-1:0]  dot_w_q;
  logic [ACC_W-1:0]         mag_q;
  logic                     zero_q, long_q;
  logic [ROOT_W-1:0]        mpl_q, mcand_q;
  logic [PP_W-1:0]          pp_q;
  logic [REM_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [ROOT_W:0]          drem_q;
  logic [NUM_W-1:0]         quo_q;
  out_item_t                out_q;

  logic [REM_W-1:0]         rem_sh, trial;
  logic [ROOT_W:0]          drem_sh;
  logic [SIM_W-2:0]         sim_mag;
  logic signed [SIM_W-1:0]  sim;

  assign stat_o.zero_norm = zero_q;
  assign out_item_o       = out_q;

  assign rem_sh  = {rem_q[REM_W-3:0], pp_q[PP_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign drem_sh = {drem_q[ROOT_W-1:0], quo_q[NUM_W-1]};

  always_comb begin
    if (quo_q > NUM_W'(ONE_Q14)) begin
      sim_mag = (SIM_W - 1)'(ONE_Q14);
    end else begin
      sim_mag = quo_q[SIM_W-2:0];
    end
    if (zero_q) begin
      sim = '0;
    end else if (dot_w_q[ACC_W-1]) begin
      sim = -signed'({1'b0, sim_mag});
    end else begin
      sim = signed'({1'b0, sim_mag});
    end
  end

  // Accumulators and pair count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= '0;
      sq_a_q <= '0;
      sq_b_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.fin_init) begin
      dot_q  <= '0;
      sq_a_q <= '0;
      sq_b_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc_add) begin
      dot_q  <= sat_add(dot_q, p_ab_q);
      sq_a_q <= sat_add(sq_a_q, p_aa_q);
      sq_b_q <= sat_add(sq_b_q, p_bb_q);
      if (cnt_q <= CNT_W'(MAX_LEN)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Product stage and the iterative finishing units.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      p_ab_q <= in_item_i.elem_a * in_item_i.elem_b;
      p_aa_q <= in_item_i.elem_a * in_item_i.elem_a;
      p_bb_q <= in_item_i.elem_b * in_item_i.elem_b;
    end
    if (cmd_i.fin_init) begin
      dot_w_q <= dot_q;
      mag_q   <= dot_q[ACC_W-1] ? (~dot_q + 1'b1) : dot_q;
      zero_q  <= (sq_a_q == '0) || (sq_b_q == '0);
      long_q  <= cnt_q > CNT_W'(MAX_LEN);
      mpl_q   <= sq_a_q[ROOT_W-1:0];
      mcand_q <= sq_b_q[ROOT_W-1:0];
      pp_q    <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end
    // Multiplier bits are taken most significant first.
    if (cmd_i.mul_step) begin
      mpl_q <= {mpl_q[ROOT_W-2:0], 1'b0};
      pp_q  <= {pp_q[PP_W-2:0], 1'b0} + (mpl_q[ROOT_W-1] ? PP_W'(mcand_q) : '0);
    end
    // Restoring square root, two product bits per step.
    if (cmd_i.sqrt_step) begin
      pp_q <= {pp_q[PP_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    // The half divisor added here rounds the quotient half away from zero.
    if (cmd_i.div_init) begin
      quo_q  <= {mag_q, {FRAC_W{1'b0}}} + NUM_W'(root_q >> 1);
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (drem_sh >= {1'b0, root_q}) begin
        drem_q <= drem_sh - {1'b0, root_q};
        quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_q.similarity  <= sim;
      out_q.dot_product <= dot_w_q;
      out_q.zero_norm   <= zero_q;
      out_q.too_long    <= long_q;
    end
  end

endmodule

// ----- rtl/cosine_similarity_stream_core.sv -----
// Streaming cosine similarity of two signed Q4.12 vectors.
// The input channel (in_valid_i, in_ready_o, in_item_i) carries one element
// pair per item; the item with last set closes the vectors. The output
// channel (out_valid_o, out_ready_i, out_item_o) carries one result item per
// vector pair: the Q1.14 similarity, the saturated Q24.24 dot product and the
// zero norm and overlong flags. Items without last produce no result.
// Element pairs are taken at one item per cycle while the vectors stream in.
// After the last item is taken, input ready drops while the finishing
// sequence runs: a bit-serial multiply of the two square sums, a restoring
// square root and a restoring divide, plus control states that drain the
// product stage, snapshot the sums, set up the divide and load the result.
// When either norm is zero the multiply, square root and divide are skipped.
// The result then sits in an output register, so the next vector can stream
// in while the result waits.
// If the receiver still holds the previous result when a new one is done,
// the block waits with input ready low until that result is taken.
// Reset (rst_ni low, asynchronous) clears the accumulators, the pair count
// and the output valid; no clearing pass is needed.
module cosine_similarity_stream_core
  import csim_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences accumulation and the finishing units.
  csim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the accumulators, the shift-add multiplier, the
  // square root and divider registers, and the result register.
  csim_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

// ----- sim/cosine_similarity_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the cosine similarity core. It runs its own copy of
// the accumulators, predicts one result item per vector pair and compares
// every result item with the oldest prediction.
module cosine_similarity_checker
  import csim_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  longint      dot_acc    = 0;
  longint      sq_a_acc   = 0;
  longint      sq_b_acc   = 0;
  int unsigned pair_cnt   = 0;
  int          mismatches = 0;
  out_item_t   expected_results[$];

  assign mismatch_count_o = mismatches;
  assign pending_o        = expected_results.size();

  function automatic longint clip_acc(longint s);
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Rounded quotient dot / floor(sqrt(sa * sb)) in Q1.14, clamped to one.
  function automatic logic signed [SIM_W-1:0] cosine_q14(longint dot, longint sa,
                                                          longint sb);
    logic [PP_W-1:0]   norm_prod;
    logic [PP_W-1:0]   trial_sq;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    logic [63:0]       mag;
    logic [63:0]       quot;
    norm_prod = sa[ROOT_W-1:0] * sb[ROOT_W-1:0];
    root = '0;
    for (int bit_idx = ROOT_W - 1; bit_idx >= 0; bit_idx--) begin
      trial    = root | (ROOT_W'(1) << bit_idx);
      trial_sq = trial * trial;
      if (trial_sq <= norm_prod) root = trial;
    end
    mag  = (dot < 0) ? 64'(-dot) : 64'(dot);
    quot = ((mag << FRAC_W) + (64'(root) >> 1)) / 64'(root);
    if (quot > ONE_Q14) quot = ONE_Q14;
    return (dot < 0) ? -SIM_W'(quot) : SIM_W'(quot);
  endfunction

  task automatic accumulate_pair(input in_item_t item);
    longint    a;
    longint    b;
    out_item_t res;
    a        = longint'($signed(item.elem_a));
    b        = longint'($signed(item.elem_b));
    dot_acc  = clip_acc(dot_acc + a * b);
    sq_a_acc = clip_acc(sq_a_acc + a * a);
    sq_b_acc = clip_acc(sq_b_acc + b * b);
    if (pair_cnt <= MAX_LEN) pair_cnt++;
    if (item.last) begin
      res.zero_norm   = (sq_a_acc == 0) || (sq_b_acc == 0);
      res.too_long    = pair_cnt > MAX_LEN;
      res.dot_product = dot_acc[ACC_W-1:0];
      res.similarity  = res.zero_norm ? '0 : cosine_q14(dot_acc, sq_a_acc, sq_b_acc);
      expected_results.push_back(res);
      dot_acc  = 0;
      sq_a_acc = 0;
      sq_b_acc = 0;
      pair_cnt = 0;
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result item with none expected: sim %0d dot %0d zn %0b tl %0b",
                 $time, got.similarity, got.dot_product, got.zero_norm, got.too_long);
    end else begin
      want = expected_results.pop_front();
      if (got.similarity !== want.similarity || got.dot_product !== want.dot_product ||
          got.zero_norm !== want.zero_norm || got.too_long !== want.too_long) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected sim %0d dot %0d zn %0b tl %0b, got sim %0d dot %0d zn %0b tl %0b",
                   $time, want.similarity, want.dot_product, want.zero_norm,
                   want.too_long, got.similarity, got.dot_product, got.zero_norm,
                   got.too_long);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dot_acc  = 0;
      sq_a_acc = 0;
      sq_b_acc = 0;
      pair_cnt = 0;
    end else begin
      if (in_valid_i && in_ready_i) accumulate_pair(in_item_i);
      if (out_valid_i && out_ready_i) compare_result(out_item_i);
    end
  end

endmodule

// ----- sim/cosine_similarity_stream_core_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the cosine similarity core. The checker beside the
// block does all prediction and comparison; this module only feeds vectors,
// throttles the result channel and reports the outcome.
module cosine_similarity_stream_core_tb;
  import csim_pkg::*;

  // How the elements of one vector pair are drawn.
  typedef enum {
    VEC_RANDOM,
    VEC_SMALL,
    VEC_SAME,
    VEC_OPPOSITE,
    VEC_SCALED,
    VEC_EXTREME,
    VEC_A_ZERO,
    VEC_B_ZERO,
    VEC_BOTH_ZERO
  } vec_shape_e;

  localparam int TOTAL_ITEMS    = 1850;
  localparam int DIRECTED_ITEMS = 18;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        mismatches;
  int        pending;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int unsigned sent_items    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cosine_similarity_stream_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  cosine_similarity_checker #(
    .MAX_LEN(MAX_LEN_DEF)
  ) checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_item_i      (out_item),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // The receiver decides afresh every cycle whether it takes a result item.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Offers one element pair, called at a falling edge, and returns at the
  // falling edge after the item was taken. Valid stays high afterwards, so a
  // back-to-back item only changes the payload.
  task automatic push_pair(input logic signed [ELEM_WIDTH-1:0] a,
                           input logic signed [ELEM_WIDTH-1:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= '{elem_a: a, elem_b: b, last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pick_pair(input vec_shape_e shape,
                           output logic signed [ELEM_WIDTH-1:0] a,
                           output logic signed [ELEM_WIDTH-1:0] b);
    a = ELEM_WIDTH'($urandom);
    b = ELEM_WIDTH'($urandom);
    case (shape)
      VEC_SMALL: begin
        a = ELEM_WIDTH'(int'($urandom_range(16)) - 8);
        b = ELEM_WIDTH'(int'($urandom_range(16)) - 8);
      end
      VEC_SAME:      b = a;
      VEC_OPPOSITE:  b = -a;
      VEC_SCALED:    b = a >>> $urandom_range(6);
      VEC_EXTREME: begin
        // Both elements come from the corners of the Q4.12 range.
        for (int k = 0; k < 2; k++) begin
          case ($urandom_range(4))
            0:       b = 16'sh8000;
            1:       b = 16'sh7fff;
            2:       b = -16'sd1;
            3:       b = 16'sd1;
            default: b = '0;
          endcase
          if (k == 0) a = b;
        end
      end
      VEC_A_ZERO:    a = '0;
      VEC_B_ZERO:    b = '0;
      VEC_BOTH_ZERO: begin
        a = '0;
        b = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_vector(input vec_shape_e shape, input int unsigned len);
    logic signed [ELEM_WIDTH-1:0] a;
    logic signed [ELEM_WIDTH-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      pick_pair(shape, a, b);
      push_pair(a, b, i == len - 1);
    end
  endtask

  // The same pair over and over.
  task automatic send_long_run(input int unsigned len,
                               input logic signed [ELEM_WIDTH-1:0] a,
                               input logic signed [ELEM_WIDTH-1:0] b);
    for (int unsigned i = 0; i < len; i++) push_pair(a, b, i == len - 1);
  endtask

  initial begin
    int          pick;
    int unsigned len;
    vec_shape_e  shape;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: one-pair vectors at the corners of the range, the zero
    // norm cases, orthogonal pairs and a plain rounding case.
    push_pair(16'sh7fff, 16'sh7fff, 1'b1);
    push_pair(16'sh8000, 16'sh8000, 1'b1);
    push_pair(16'sh8000, 16'sh7fff, 1'b1);
    push_pair(16'sh7fff, 16'sh8000, 1'b1);
    push_pair(16'sd0, 16'sh8000, 1'b1);
    push_pair(-16'sd1, 16'sd0, 1'b1);
    push_pair(16'sd0, 16'sd0, 1'b1);
    push_pair(16'sd1, 16'sd0, 1'b0);
    push_pair(16'sd0, 16'sd1, 1'b0);
    push_pair(16'sd0, 16'sd0, 1'b1);
    push_pair(16'sd16384, 16'sd16384, 1'b0);
    push_pair(16'sd16384, -16'sd16384, 1'b1);
    push_pair(16'sd3, 16'sd1, 1'b0);
    push_pair(16'sd1, 16'sd3, 1'b1);
    push_pair(-16'sd3, 16'sd1, 1'b0);
    push_pair(16'sd1, 16'sd3, 1'b1);
    push_pair(16'sd5, 16'sd0, 1'b0);
    push_pair(16'sd0, 16'sd0, 1'b1);

    // Overlong vector of corner values, one pair past the maximum length, with
    // the dot product going to either sign. Runs with no idling on either side.
    send_long_run(MAX_LEN_DEF + 1, 16'sh8000, $urandom_range(1) ? 16'sh7fff : 16'sh8000);
    sent_items = DIRECTED_ITEMS + MAX_LEN_DEF + 1;

    // Random part with idling on both sides.
    in_idle_pct   = 8;
    out_stall_pct = 8;
    while (sent_items < TOTAL_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40)      shape = VEC_RANDOM;
      else if (pick < 55) shape = VEC_SMALL;
      else if (pick < 62) shape = VEC_SAME;
      else if (pick < 68) shape = VEC_OPPOSITE;
      else if (pick < 76) shape = VEC_SCALED;
      else if (pick < 84) shape = VEC_EXTREME;
      else if (pick < 89) shape = VEC_A_ZERO;
      else if (pick < 94) shape = VEC_B_ZERO;
      else                shape = VEC_BOTH_ZERO;
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      send_vector(shape, len);
      sent_items += len;
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then give the block time to show any
    // result item that should never have come.
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The slowest correct run stays well below a third of this.
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csim_pkg.sv
rtl/csim_ctrl.sv
rtl/csim_dp.sv
rtl/cosine_similarity_stream_core.sv
sim/cosine_similarity_checker.sv
sim/cosine_similarity_stream_core_tb.sv
